@@ hw/rtl/tpbi_pkg.sv @@
// Shared types and constants of the trace pipe busy interval extractor.
package tpbi_pkg;

    localparam int CTRL_SHIFT  = 12;
    localparam int CTRL_W      = 4;
    localparam int LOW_W       = 12;
    localparam int CHAN_FULL_W = 11;
    localparam int CHAN_OUT_W  = 6;
    localparam int CYC_W       = 64;
    localparam int DELTA_W     = 32;

    localparam logic [CTRL_W-1:0] CTRL_MARK_LO     = 4'h0;
    localparam logic [CTRL_W-1:0] CTRL_MARK_HI     = 4'h5;
    localparam logic [CTRL_W-1:0] CTRL_MARK_REGION = 4'hA;
    localparam logic [CTRL_W-1:0] CTRL_PIPE        = 4'hF;

    localparam logic EV_INTERVAL = 1'b0;
    localparam logic EV_MARK     = 1'b1;

    typedef struct packed {
        logic [7:0]          core_id;
        logic [1:0]          core_type;
        logic [15:0]         record_word;
        logic [DELTA_W-1:0]  cycle_delta;
    } rec_word_t;

    typedef struct packed {
        logic                  event_kind;
        logic [CHAN_OUT_W-1:0] channel_index;
        logic [CTRL_W-1:0]     lane_code;
        logic [LOW_W-1:0]      mark_id;
        logic [CYC_W-1:0]      start_cycle;
        logic [CYC_W-1:0]      duration;
        logic                  last;
    } evt_word_t;

    typedef struct packed {
        logic              act;
        logic              pipe_op;
        logic [CTRL_W-1:0] ctrl;
        logic [LOW_W-1:0]  low;
    } dec_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MARK,
        ST_SCAN
    } state_t;

endpackage

@@ hw/rtl/tpbi_decode.sv @@
// Record decode: channel number, range checks and control code class.
module tpbi_decode #(
    parameter int CHANNELS  = 64,
    parameter int SUB_CORES = 2
) (
    input  tpbi_pkg::rec_word_t          rec,
    output logic [$clog2(CHANNELS)-1:0]  chan,
    output tpbi_pkg::dec_t               dec
);
    localparam int CH_W = $clog2(CHANNELS);

    logic [tpbi_pkg::CHAN_FULL_W-1:0] chan_full;
    logic                             type_ok;
    logic                             chan_ok;
    logic                             code_ok;
    logic [tpbi_pkg::CTRL_W-1:0]      ctrl;

    always_comb
    begin
        chan_full = tpbi_pkg::CHAN_FULL_W'(rec.core_id)
                    * tpbi_pkg::CHAN_FULL_W'(SUB_CORES)
                    + tpbi_pkg::CHAN_FULL_W'(rec.core_type);
        type_ok   = {1'b0, rec.core_type} < 3'(SUB_CORES);
        chan_ok   = chan_full < tpbi_pkg::CHAN_FULL_W'(CHANNELS);
        ctrl      = rec.record_word[tpbi_pkg::CTRL_SHIFT +: tpbi_pkg::CTRL_W];
        code_ok   = ctrl inside {[tpbi_pkg::CTRL_MARK_LO:tpbi_pkg::CTRL_MARK_HI],
                                 tpbi_pkg::CTRL_MARK_REGION, tpbi_pkg::CTRL_PIPE};
        chan        = chan_full[CH_W-1:0];
        dec.act     = type_ok && chan_ok && code_ok;
        dec.pipe_op = (ctrl == tpbi_pkg::CTRL_PIPE);
        dec.ctrl    = ctrl;
        dec.low     = rec.record_word[tpbi_pkg::LOW_W-1:0];
    end

endmodule

@@ hw/rtl/tpbi_state_mem.sv @@
// Per-channel state memories: cycle count and the row of pipe busy starts.
module tpbi_state_mem #(
    parameter int CHANNELS = 64,
    parameter int PIPES    = 8
) (
    input  logic                                  clk,
    input  logic                                  rd_en,
    input  logic [$clog2(CHANNELS)-1:0]           rd_addr,
    input  logic                                  cnt_we,
    input  logic                                  row_we,
    input  logic [$clog2(CHANNELS)-1:0]           wr_addr,
    input  logic [tpbi_pkg::CYC_W-1:0]            wr_count,
    input  logic [PIPES*tpbi_pkg::CYC_W-1:0]      wr_row,
    output logic [tpbi_pkg::CYC_W-1:0]            rd_count,
    output logic [PIPES*tpbi_pkg::CYC_W-1:0]      rd_row
);
    localparam int ROW_W = PIPES * tpbi_pkg::CYC_W;

    logic [tpbi_pkg::CYC_W-1:0] count_mem [CHANNELS];
    logic [ROW_W-1:0]           row_mem   [CHANNELS];
    logic [tpbi_pkg::CYC_W-1:0] rd_count_reg;
    logic [ROW_W-1:0]           rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        if (rd_en)
        begin
            rd_count_reg <= count_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= row_mem[rd_addr];
        end
    end

    assign rd_count = rd_count_reg;
    assign rd_row   = rd_row_reg;

endmodule

@@ hw/rtl/tpbi_out_stage.sv @@
// Output register: holds one event word until the consumer takes it.
module tpbi_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tpbi_pkg::evt_word_t load_word,
    output logic                free,
    output logic                evt_valid,
    input  logic                evt_ready,
    output tpbi_pkg::evt_word_t evt_word
);
    logic                valid_reg;
    logic                valid_next;
    tpbi_pkg::evt_word_t word_reg;

    assign free = !valid_reg || evt_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (evt_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign evt_valid = valid_reg;
    assign evt_word  = word_reg;

endmodule

@@ hw/rtl/trace_pipe_busy_interval_extractor_unit.sv @@
// Top level of the trace pipe busy interval extractor: sequencer around the state memories.
// A record is taken only in the idle state. A mark word is loaded into the output register
//   in the load state, or in the mark state once that register is free; the interval words
//   of a busy report leave from the scan state, one word per cycle while the register is free.
//   A new record waits until the last one is through; a dropped or ignored one stays idle.
// Reset: asynchronous, active low; a clearing pass then zeroes both memories, one channel
//   row per cycle, while rec_ready stays low.
module trace_pipe_busy_interval_extractor_unit #(
    parameter int CHANNELS  = 64,
    parameter int PIPES     = 8,
    parameter int SUB_CORES = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    output logic                rec_ready,
    input  tpbi_pkg::rec_word_t rec_word,
    output logic                evt_valid,
    input  logic                evt_ready,
    output tpbi_pkg::evt_word_t evt_word
);
    localparam int CH_W    = $clog2(CHANNELS);
    localparam int CYC_W   = tpbi_pkg::CYC_W;
    localparam int ROW_W   = PIPES * CYC_W;
    localparam int PIDX_W  = (PIPES > 1) ? $clog2(PIPES) : 1;

    // decode of the incoming word
    logic [CH_W-1:0]  dec_chan;
    tpbi_pkg::dec_t   dec;

    // sequencer state
    tpbi_pkg::state_t state_reg;
    tpbi_pkg::state_t state_next;
    logic [CH_W-1:0]  clr_reg;

    // held record
    logic [CH_W-1:0]                chan_reg;
    logic                           pipe_op_reg;
    logic [tpbi_pkg::CTRL_W-1:0]    ctrl_reg;
    logic [tpbi_pkg::LOW_W-1:0]     low_reg;
    logic [tpbi_pkg::DELTA_W-1:0]   delta_reg;

    // working copy of the channel row
    logic [CYC_W-1:0] now_reg;
    logic [ROW_W-1:0] old_row_reg;
    logic [PIPES-1:0] pend_reg;
    logic [PIPES-1:0] pend_next;

    // memory ports
    logic             rd_en;
    logic             cnt_we;
    logic             row_we;
    logic [CH_W-1:0]  wr_addr;
    logic [CYC_W-1:0] wr_count;
    logic [ROW_W-1:0] wr_row;
    logic [CYC_W-1:0] rd_count;
    logic [ROW_W-1:0] rd_row;

    // per-record combinational results
    logic [CYC_W-1:0] now;
    logic [ROW_W-1:0] new_row;
    logic [PIPES-1:0] emit_mask;
    logic [PIPES-1:0] pick;
    logic [PIPES-1:0] rest;
    logic [PIDX_W-1:0] pick_idx;
    logic [CYC_W-1:0] pick_start;
    logic [CYC_W-1:0] mark_start;

    // output register
    logic                out_free;
    logic                out_load;
    tpbi_pkg::evt_word_t mark_word;
    tpbi_pkg::evt_word_t ival_word;
    tpbi_pkg::evt_word_t load_word;

    tpbi_decode #(
        .CHANNELS  (CHANNELS),
        .SUB_CORES (SUB_CORES)
    ) u_decode (
        .rec  (rec_word),
        .chan (dec_chan),
        .dec  (dec)
    );

    tpbi_state_mem #(
        .CHANNELS (CHANNELS),
        .PIPES    (PIPES)
    ) u_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (dec_chan),
        .cnt_we   (cnt_we),
        .row_we   (row_we),
        .wr_addr  (wr_addr),
        .wr_count (wr_count),
        .wr_row   (wr_row),
        .rd_count (rd_count),
        .rd_row   (rd_row)
    );

    tpbi_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_word (load_word),
        .free      (out_free),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_word  (evt_word)
    );

    // Advance the channel count and work out the new row: a busy pipe with no start takes
    // the current count, an idle pipe drops its start, and every idle pipe that held a
    // start owes one interval word.
    always_comb
    begin
        logic [CYC_W-1:0] start;
        logic             busy;
        now = rd_count + CYC_W'(delta_reg);
        for (int p = 0; p < PIPES; p++)
        begin
            start        = rd_row[p*CYC_W +: CYC_W];
            busy         = low_reg[p];
            emit_mask[p] = !busy && (start != '0);
            new_row[p*CYC_W +: CYC_W] = !busy ? '0 : ((start == '0) ? now : start);
        end
    end

    // Pick the lowest pending pipe; the word is last when no other pipe remains.
    always_comb
    begin
        pick     = pend_reg & (~pend_reg + PIPES'(1));
        rest     = pend_reg & ~pick;
        pick_idx = '0;
        for (int i = 0; i < PIPES; i++)
        begin
            if (pick[i])
            begin
                pick_idx = PIDX_W'(i);
            end
        end
        pick_start = old_row_reg[pick_idx*CYC_W +: CYC_W];
    end

    // A mark leaves straight from the load cycle when the output register is free.
    assign mark_start = (state_reg == tpbi_pkg::ST_LOAD) ? now : now_reg;

    always_comb
    begin
        mark_word.event_kind    = tpbi_pkg::EV_MARK;
        mark_word.channel_index = tpbi_pkg::CHAN_OUT_W'(chan_reg);
        mark_word.lane_code     = ctrl_reg;
        mark_word.mark_id       = low_reg;
        mark_word.start_cycle   = mark_start;
        mark_word.duration      = CYC_W'(1);
        mark_word.last          = 1'b1;

        ival_word.event_kind    = tpbi_pkg::EV_INTERVAL;
        ival_word.channel_index = tpbi_pkg::CHAN_OUT_W'(chan_reg);
        ival_word.lane_code     = tpbi_pkg::CTRL_W'(pick_idx);
        ival_word.mark_id       = '0;
        ival_word.start_cycle   = pick_start;
        ival_word.duration      = now_reg - pick_start;
        ival_word.last          = (rest == '0);
    end

    // Sequencer: clear, take a record, read-modify-write its channel, drain its words.
    always_comb
    begin
        state_next = state_reg;
        rec_ready  = 1'b0;
        rd_en      = 1'b0;
        cnt_we     = 1'b0;
        row_we     = 1'b0;
        wr_addr    = chan_reg;
        wr_count   = now;
        wr_row     = new_row;
        out_load   = 1'b0;
        load_word  = mark_word;
        pend_next  = pend_reg;
        case (state_reg)
            tpbi_pkg::ST_CLEAR:
            begin
                cnt_we   = 1'b1;
                row_we   = 1'b1;
                wr_addr  = clr_reg;
                wr_count = '0;
                wr_row   = '0;
                if (clr_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = tpbi_pkg::ST_IDLE;
                end
            end
            tpbi_pkg::ST_IDLE:
            begin
                rec_ready = 1'b1;
                rd_en     = rec_valid && dec.act;
                if (rec_valid && dec.act)
                begin
                    state_next = tpbi_pkg::ST_LOAD;
                end
            end
            tpbi_pkg::ST_LOAD:
            begin
                cnt_we = 1'b1;
                row_we = pipe_op_reg;
                if (pipe_op_reg)
                begin
                    pend_next  = emit_mask;
                    state_next = (emit_mask != '0) ? tpbi_pkg::ST_SCAN : tpbi_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = tpbi_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tpbi_pkg::ST_MARK;
                end
            end
            tpbi_pkg::ST_MARK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = tpbi_pkg::ST_IDLE;
                end
            end
            tpbi_pkg::ST_SCAN:
            begin
                load_word = ival_word;
                if (out_free)
                begin
                    out_load  = 1'b1;
                    pend_next = rest;
                    if (rest == '0)
                    begin
                        state_next = tpbi_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tpbi_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpbi_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (state_reg == tpbi_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + CH_W'(1);
            end
        end
    end

    // Hold the record and the working row; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
        begin
            chan_reg    <= dec_chan;
            pipe_op_reg <= dec.pipe_op;
            ctrl_reg    <= dec.ctrl;
            low_reg     <= dec.low;
            delta_reg   <= rec_word.cycle_delta;
        end
        if (state_reg == tpbi_pkg::ST_LOAD)
        begin
            now_reg     <= now;
            old_row_reg <= rd_row;
        end
    end

endmodule

@@ hw/rtl/tpbi_checker.sv @@
// Port-level checker for the extractor, bound to the top level.
module tpbi_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rec_ready,
    input logic                evt_valid,
    input logic                evt_ready,
    input tpbi_pkg::evt_word_t evt_word
);

    // a stalled word holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_word))
        else $error("event word changed while stalled");

    // a mark is a single one-cycle word
    a_mark_form: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_word.event_kind == tpbi_pkg::EV_MARK)
        |-> (evt_word.duration == 64'd1) && evt_word.last)
        else $error("malformed mark word");

    // intervals carry no region id
    a_ival_form: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_word.event_kind == tpbi_pkg::EV_INTERVAL)
        |-> (evt_word.mark_id == '0))
        else $error("interval word with region id");

    // right after reset is released, no record is taken and no event word is offered
    a_clear_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rec_ready && !evt_valid)
        else $error("record taken during clearing pass");

endmodule

bind trace_pipe_busy_interval_extractor_unit tpbi_checker u_tpbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_ready (rec_ready),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt_word  (evt_word)
);

@@ test/trace_pipe_busy_interval_extractor_unit_tb.sv @@
// Self-checking testbench for the trace pipe busy interval extractor top level.
`timescale 1ns / 100ps

module trace_pipe_busy_interval_extractor_unit_tb;

    localparam int CHANNELS  = 64;
    localparam int PIPES     = 8;
    localparam int SUB_CORES = 2;

    localparam int CTRL_SHIFT = tpbi_pkg::CTRL_SHIFT;
    localparam int CTRL_W     = tpbi_pkg::CTRL_W;
    localparam int LOW_W      = tpbi_pkg::LOW_W;
    localparam int CHAN_OUT_W = tpbi_pkg::CHAN_OUT_W;
    localparam int CYC_W      = tpbi_pkg::CYC_W;
    localparam int DELTA_W    = tpbi_pkg::DELTA_W;

    // Random record words offered after the directed rows.
    localparam int RANDOM_WORDS = 236;
    // Receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES  = 200;
    // Cycles with no handshake on either side before the run is abandoned.
    localparam int STALL_LIMIT  = 4000;
    // Drain time after the last expected word.
    localparam int DRAIN_CYCLES = 16;

    // Control codes the block ignores: the two runs between the mark codes and the pipe code.
    localparam logic [CTRL_W-1:0] CTRL_SKIP_A = 4'h6;
    localparam logic [CTRL_W-1:0] CTRL_SKIP_B = 4'h9;
    localparam logic [CTRL_W-1:0] CTRL_SKIP_C = 4'hB;
    localparam logic [CTRL_W-1:0] CTRL_SKIP_D = 4'hE;

    // How a directed row is checked: by the predictor, as dropping everything, or as one
    // mark word whose start cycle is typed into the row.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_MARK
    } chk_t;

    typedef struct packed {
        logic [7:0]         core_id;
        logic [1:0]         core_type;
        logic [15:0]        word;
        logic [DELTA_W-1:0] delta;
        chk_t               chk;
        logic [CYC_W-1:0]   mark_start;
    } row_t;

    localparam int N_ROWS = 24;

    // Directed rows, walked in order straight after the clearing pass.
    localparam row_t DIRECTED [N_ROWS] = '{
        // first mark on a fresh channel sits at count zero
        '{8'd0,   2'd0, {tpbi_pkg::CTRL_MARK_LO, 12'h000},  32'd0,     CHK_MARK,  64'd0},
        // sub-core kinds two and three are dropped
        '{8'd0,   2'd2, {tpbi_pkg::CTRL_MARK_LO, 12'h000},  32'd5,     CHK_NONE,  64'd0},
        '{8'd255, 2'd3, {tpbi_pkg::CTRL_MARK_HI, 12'hfff},  32'hffffffff, CHK_NONE, 64'd0},
        // channel 64 and the top channel number lie past the channel limit
        '{8'd32,  2'd0, {tpbi_pkg::CTRL_MARK_LO, 12'h000},  32'd9,     CHK_NONE,  64'd0},
        '{8'd255, 2'd1, {tpbi_pkg::CTRL_PIPE, 12'hfff},     32'd1,     CHK_NONE,  64'd0},
        // ignored control codes leave the count alone
        '{8'd0,   2'd0, {CTRL_SKIP_A, 12'h123},             32'd5,     CHK_NONE,  64'd0},
        '{8'd0,   2'd0, {CTRL_SKIP_B, 12'hfff},             32'd5,     CHK_NONE,  64'd0},
        '{8'd0,   2'd0, {CTRL_SKIP_C, 12'h000},             32'd5,     CHK_NONE,  64'd0},
        '{8'd0,   2'd0, {CTRL_SKIP_D, 12'h800},             32'd5,     CHK_NONE,  64'd0},
        // largest delta and widest region id
        '{8'd0,   2'd0, {tpbi_pkg::CTRL_MARK_HI, 12'hfff},  32'hffffffff, CHK_MARK,
          64'hffffffff},
        // region mark on the top channel
        '{8'd31,  2'd1, {tpbi_pkg::CTRL_MARK_REGION, 12'habc}, 32'd7,  CHK_MARK,  64'd7},
        // remaining mark codes
        '{8'd0,   2'd1, {tpbi_pkg::CTRL_MARK_LO + 4'd1, 12'h001}, 32'd1, CHK_MODEL, 64'd0},
        '{8'd0,   2'd1, {tpbi_pkg::CTRL_MARK_LO + 4'd2, 12'h7ff}, 32'd2, CHK_MODEL, 64'd0},
        '{8'd0,   2'd1, {tpbi_pkg::CTRL_MARK_LO + 4'd3, 12'h800}, 32'd3, CHK_MODEL, 64'd0},
        '{8'd0,   2'd1, {tpbi_pkg::CTRL_MARK_LO + 4'd4, 12'h5a5}, 32'd4, CHK_MODEL, 64'd0},
        // busy at count zero keeps the start at zero, so the pipes stay idle
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'h0ff},     32'd0,     CHK_NONE,  64'd0},
        // idle with no start says nothing
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'h000},     32'd0,     CHK_NONE,  64'd0},
        // every pipe starts at ten; mask bits above the pipes are ignored
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'hfff},     32'd10,    CHK_NONE,  64'd0},
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'hf00},     32'd5,     CHK_MODEL, 64'd0},
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'h0a5},     32'd3,     CHK_MODEL, 64'd0},
        // zero delta: pipes that drop out give zero-length intervals
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'h0f0},     32'd0,     CHK_MODEL, 64'd0},
        '{8'd1,   2'd0, {tpbi_pkg::CTRL_PIPE, 12'h000},     32'hffffffff, CHK_MODEL, 64'd0},
        '{8'd0,   2'd1, {tpbi_pkg::CTRL_MARK_REGION, 12'h555}, 32'h80000000, CHK_MODEL,
          64'd0},
        '{8'd0,   2'd1, {tpbi_pkg::CTRL_PIPE, 12'h001},     32'h7fffffff, CHK_MODEL, 64'd0}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                rec_valid = 1'b0;
    logic                rec_ready;
    tpbi_pkg::rec_word_t rec_word  = '0;
    logic                evt_valid;
    logic                evt_ready = 1'b0;
    tpbi_pkg::evt_word_t evt_word;

    // Predictor state: per-channel cycle count and per-pipe busy start (zero is idle).
    logic [CYC_W-1:0] chan_count [CHANNELS];
    logic [CYC_W-1:0] pipe_start [CHANNELS][PIPES];

    tpbi_pkg::evt_word_t step_events [$];     // words caused by the record just taken
    tpbi_pkg::evt_word_t pending_events [$];  // words still owed by the block, oldest first
    int        mismatches   = 0;
    int        stall_cycles = 0;
    bit        calm         = 1'b0; // no idling on either side
    bit        want_hold    = 1'b0;
    bit        hold_done    = 1'b0;

    trace_pipe_busy_interval_extractor_unit #(
        .CHANNELS  (CHANNELS),
        .PIPES     (PIPES),
        .SUB_CORES (SUB_CORES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_word  (rec_word),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_word  (evt_word)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        foreach (chan_count[c])
        begin
            chan_count[c] = '0;
            foreach (pipe_start[c][p])
                pipe_start[c][p] = '0;
        end
    end

    // Work out the event words one record causes and advance the channel state.
    function automatic void derive_trace_events(input tpbi_pkg::rec_word_t r);
        int unsigned         chan;
        logic [CTRL_W-1:0]   ctrl;
        logic [LOW_W-1:0]    low;
        logic [CYC_W-1:0]    now;
        tpbi_pkg::evt_word_t e;
        step_events.delete();
        // drop bad sub-core kinds and channels past the limit
        if (r.core_type >= SUB_CORES)
            return;
        chan = r.core_id * SUB_CORES + r.core_type;
        if (chan >= CHANNELS)
            return;
        ctrl = r.record_word[CTRL_SHIFT +: CTRL_W];
        low  = r.record_word[LOW_W-1:0];
        if (ctrl == tpbi_pkg::CTRL_PIPE)
        begin
            chan_count[chan] = chan_count[chan] + CYC_W'(r.cycle_delta);
            now             = chan_count[chan];
            for (int p = 0; p < PIPES; p++)
            begin
                if (!low[p])
                begin
                    // busy to idle closes the interval; a zero start never opened one
                    if (pipe_start[chan][p] != '0)
                    begin
                        e               = '0;
                        e.event_kind    = tpbi_pkg::EV_INTERVAL;
                        e.channel_index = CHAN_OUT_W'(chan);
                        e.lane_code     = CTRL_W'(p);
                        e.start_cycle   = pipe_start[chan][p];
                        e.duration      = now - pipe_start[chan][p];
                        step_events.push_back(e);
                        pipe_start[chan][p] = '0;
                    end
                end
                else if (pipe_start[chan][p] == '0)
                    pipe_start[chan][p] = now;
            end
            if (step_events.size() > 0)
                step_events[step_events.size() - 1].last = 1'b1;
        end
        else if (ctrl <= tpbi_pkg::CTRL_MARK_HI || ctrl == tpbi_pkg::CTRL_MARK_REGION)
        begin
            chan_count[chan] = chan_count[chan] + CYC_W'(r.cycle_delta);
            e               = '0;
            e.event_kind    = tpbi_pkg::EV_MARK;
            e.channel_index = CHAN_OUT_W'(chan);
            e.lane_code     = ctrl;
            e.mark_id       = low;
            e.start_cycle   = chan_count[chan];
            e.duration      = 64'd1;
            e.last          = 1'b1;
            step_events.push_back(e);
        end
    endfunction

    // Offer one record word, hold it until taken, then queue what it owes.
    task automatic offer_record(input tpbi_pkg::rec_word_t r, input chk_t chk,
                                input logic [CYC_W-1:0] mark_start);
        tpbi_pkg::evt_word_t e;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            rec_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        rec_valid <= 1'b1;
        rec_word  <= r;
        @(posedge clk);
        while (!rec_ready)
            @(posedge clk);
        derive_trace_events(r);
        if (chk == CHK_MODEL)
        begin
            foreach (step_events[k])
                pending_events.push_back(step_events[k]);
        end
        else if (chk == CHK_MARK)
        begin
            e               = '0;
            e.event_kind    = tpbi_pkg::EV_MARK;
            e.channel_index = CHAN_OUT_W'(r.core_id * SUB_CORES + r.core_type);
            e.lane_code     = r.record_word[CTRL_SHIFT +: CTRL_W];
            e.mark_id       = r.record_word[LOW_W-1:0];
            e.start_cycle   = mark_start;
            e.duration      = 64'd1;
            e.last          = 1'b1;
            pending_events.push_back(e);
        end
    endtask

    // Random record: mostly live channels close together so pipes open and close often,
    // with a share of dropped and ignored noise.
    function automatic tpbi_pkg::rec_word_t random_record();
        tpbi_pkg::rec_word_t r;
        int unsigned         pick;
        r.core_id   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        r.core_type = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1));
        r.record_word[LOW_W-1:0] = LOW_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.record_word[CTRL_SHIFT +: CTRL_W] = tpbi_pkg::CTRL_PIPE;
        else if (pick < 88)
            r.record_word[CTRL_SHIFT +: CTRL_W] = ($urandom_range(0, 6) == 0)
                ? tpbi_pkg::CTRL_MARK_REGION
                : CTRL_W'($urandom_range(tpbi_pkg::CTRL_MARK_LO, tpbi_pkg::CTRL_MARK_HI));
        else if (pick < 94)
            r.record_word[CTRL_SHIFT +: CTRL_W] =
                CTRL_W'($urandom_range(CTRL_SKIP_A, CTRL_SKIP_B));
        else
            r.record_word[CTRL_SHIFT +: CTRL_W] =
                CTRL_W'($urandom_range(CTRL_SKIP_C, CTRL_SKIP_D));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.cycle_delta = '0;
        else if (pick < 7)
            r.cycle_delta = DELTA_W'($urandom_range(1, 1000));
        else
            r.cycle_delta = DELTA_W'($urandom);
        return r;
    endfunction

    // Sender: directed rows, then the random stream with one drain pause mid-way.
    initial
    begin : record_side
        int  used;
        bit  paused;
        used   = 0;
        paused = 1'b0;
        wait (rst_n);
        @(posedge clk);
        for (int i = 0; i < N_ROWS; i++)
            offer_record({DIRECTED[i].core_id, DIRECTED[i].core_type,
                          DIRECTED[i].word, DIRECTED[i].delta},
                         DIRECTED[i].chk, DIRECTED[i].mark_start);
        while (used < RANDOM_WORDS)
        begin
            // ask the receiver for its long hold-off; keep offering meanwhile
            if (used >= 80)
                want_hold = 1'b1;
            // drop valid and wait for every owed word before carrying on
            if (used >= 150 && !paused)
            begin
                paused = 1'b1;
                rec_valid <= 1'b0;
                while (pending_events.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            calm = (used >= 210);
            offer_record(random_record(), CHK_MODEL, '0);
            used++;
        end
        rec_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off on request, steady ready when calm.
    initial
    begin : event_side
        int   span;
        logic level;
        wait (rst_n);
        forever
        begin
            if (want_hold && !hold_done)
            begin
                hold_done = 1'b1;
                level     = 1'b0;
                span      = HOLD_CYCLES;
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                level = 1'b1;
                span  = $urandom_range(1, 20);
            end
            else
            begin
                level = 1'b0;
                span  = $urandom_range(1, 11);
            end
            repeat (span)
            begin
                @(posedge clk);
                evt_ready <= level;
            end
        end
    end

    function automatic int field_bad(input string name, input logic [CYC_W-1:0] want,
                                     input logic [CYC_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Compare each accepted event word with the oldest one owed.
    always @(posedge clk)
    begin : event_check
        tpbi_pkg::evt_word_t want;
        if (rst_n && evt_valid && evt_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: event word with none expected, got %p", $time, evt_word);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                mismatches += field_bad("event_kind", CYC_W'(want.event_kind),
                                        CYC_W'(evt_word.event_kind));
                mismatches += field_bad("channel_index", CYC_W'(want.channel_index),
                                        CYC_W'(evt_word.channel_index));
                mismatches += field_bad("lane_code", CYC_W'(want.lane_code),
                                        CYC_W'(evt_word.lane_code));
                mismatches += field_bad("mark_id", CYC_W'(want.mark_id),
                                        CYC_W'(evt_word.mark_id));
                mismatches += field_bad("start_cycle", want.start_cycle, evt_word.start_cycle);
                mismatches += field_bad("duration", want.duration, evt_word.duration);
                mismatches += field_bad("last", CYC_W'(want.last), CYC_W'(evt_word.last));
            end
        end
    end

    // Watchdog: abandon the run once nothing has moved on either side for too long.
    always @(posedge clk)
    begin
        if ((rec_valid && rec_ready) || (evt_valid && evt_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
